FILE: hw/rtl/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helpers of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam int BYTE_W = 8;
	localparam int KIND_W = 2;
	localparam int CODE_W = 3;

	typedef enum logic [KIND_W-1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [CODE_W-1:0] {
		ERR_NONE      = 3'd0,
		ERR_BAD_HEX   = 3'd1,
		ERR_BAD_SURR  = 3'd2,
		ERR_BAD_CP    = 3'd3,
		ERR_NO_CLOSE  = 3'd4
	} err_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CTL_BS    = 8'h08;
	localparam logic [7:0] CTL_FF    = 8'h0c;
	localparam logic [7:0] CTL_LF    = 8'h0a;
	localparam logic [7:0] CTL_CR    = 8'h0d;
	localparam logic [7:0] CTL_TAB   = 8'h09;

	localparam logic [20:0] CP_TWO_BYTE   = 21'h00080;
	localparam logic [20:0] CP_THREE_BYTE = 21'h00800;
	localparam logic [20:0] CP_FOUR_BYTE  = 21'h10000;

	localparam logic [5:0] SURR_HIGH = 6'b110110;
	localparam logic [5:0] SURR_LOW  = 6'b110111;
	localparam logic [4:0] SURR_ANY  = 5'b11011;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		kind_t             kind;
		err_t              code;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.val = 4'(c - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic res_t mk_res(input kind_t k, input logic [7:0] b, input err_t e);
		res_t r;
		r.out_byte = b;
		r.kind     = k;
		r.code     = e;
		return r;
	endfunction

endpackage

FILE: hw/rtl/jsu_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_in_if
// Raw string body channel: one byte per word.
// ----------------------------------------------------------------------------
interface jsu_in_if;
	logic                       valid;
	logic                       ready;
	logic [jsu_pkg::BYTE_W-1:0] in_byte;
	logic                       starts_string;

	modport source (output valid, output in_byte, output starts_string, input ready);
	modport sink (input valid, input in_byte, input starts_string, output ready);
endinterface

FILE: hw/rtl/jsu_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_out_if
// Decoded result channel: one result per word.
// ----------------------------------------------------------------------------
interface jsu_out_if;
	logic                       valid;
	logic                       ready;
	logic [jsu_pkg::BYTE_W-1:0] out_byte;
	logic [jsu_pkg::KIND_W-1:0] result_kind;
	logic [jsu_pkg::CODE_W-1:0] error_code;
	logic                       last_in_run;

	modport source (output valid, output out_byte, output result_kind, output error_code,
		output last_in_run, input ready);
	modport sink (input valid, input out_byte, input result_kind, input error_code,
		input last_in_run, output ready);
endinterface

FILE: hw/rtl/jsu_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_cfg_if
// Configuration write channel for the unicode decode enable.
// ----------------------------------------------------------------------------
interface jsu_cfg_if;
	logic valid;
	logic ready;
	logic decode_unicode;

	modport source (output valid, output decode_unicode, input ready);
	modport sink (input valid, input decode_unicode, output ready);
endinterface

FILE: hw/rtl/json_string_unescape_utf8_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// JSON string body unescaper with UTF-8 output of unicode escapes.
// ----------------------------------------------------------------------------
// Usage:
//   raw     : bytes of a string body, starting after the opening quote; set
//             starts_string on the first byte of each string.
//   decoded : one word per result (data byte, end of string or error), with
//             last_in_run marking the final result of an input byte.
//   cfg     : writes decode_unicode (reset 1); write only while idle.
//   Each byte is registered, decoded combinationally and its 0 to 4 results
//   are loaded into a result buffer that drives the output. A byte is taken
//   every cycle while results keep up: the result buffer drains one word a
//   cycle while the receiver is ready, so a byte that expands into several
//   results (UTF-8 of a unicode escape, backslash pass-through) holds the
//   input while its results drain. Bytes that give no result pass at one per
//   cycle. When the receiver stalls, the buffer holds, then the input
//   register fills and ready drops. Reset empties both registers, sets the
//   decoder idle (bytes ignored until starts_string) and enables decoding.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top (
	input  logic      clk,
	input  logic      arst_n,
	jsu_in_if.sink    raw,
	jsu_out_if.source decoded,
	jsu_cfg_if.sink   cfg
);

	typedef enum logic [6:0] {
		PH_IDLE = 7'b0000001,
		PH_TEXT = 7'b0000010,
		PH_ESC  = 7'b0000100,
		PH_HI   = 7'b0001000,
		PH_BSL  = 7'b0010000,
		PH_UCH  = 7'b0100000,
		PH_LO   = 7'b1000000
	} phase_t;

	logic                       vld_s1;
	logic [jsu_pkg::BYTE_W-1:0] byte_s1;
	logic                       start_s1;

	jsu_pkg::res_t              res_s2 [4];
	logic [2:0]                 cnt_s2;

	phase_t                     ph_q, ph_d, ph_cur;
	logic [1:0]                 dig_q, dig_d;
	logic [15:0]                fu_q, fu_d;
	logic [15:0]                su_q, su_d;
	logic                       dec_q;

	jsu_pkg::res_t              r [4];
	logic [2:0]                 n;
	logic                       do_plain;
	logic                       do_enc;
	logic [20:0]                cp;
	jsu_pkg::hex_t              h;

	logic                       buf_free;
	logic                       adv;
	logic                       out_hs;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			r[i] = '0;
		end
		n        = 3'd0;
		ph_d     = ph_q;
		dig_d    = dig_q;
		fu_d     = fu_q;
		su_d     = su_q;
		do_plain = 1'b0;
		do_enc   = 1'b0;
		cp       = '0;
		ph_cur   = ph_q;
		h        = jsu_pkg::hex_digit(byte_s1);
		if (start_s1) begin
			ph_cur = PH_TEXT;
			fu_d   = '0;
			su_d   = '0;
		end
		unique case (ph_cur)
			PH_TEXT: begin
				do_plain = 1'b1;
			end
			PH_ESC: begin
				ph_d = PH_TEXT;
				case (byte_s1)
					jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH, jsu_pkg::CH_QUOTE: begin
						r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, byte_s1, jsu_pkg::ERR_NONE);
						n    = 3'd1;
					end
					jsu_pkg::CH_B: begin
						r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, jsu_pkg::CTL_BS, jsu_pkg::ERR_NONE);
						n    = 3'd1;
					end
					jsu_pkg::CH_F: begin
						r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, jsu_pkg::CTL_FF, jsu_pkg::ERR_NONE);
						n    = 3'd1;
					end
					jsu_pkg::CH_N: begin
						r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, jsu_pkg::CTL_LF, jsu_pkg::ERR_NONE);
						n    = 3'd1;
					end
					jsu_pkg::CH_R: begin
						r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, jsu_pkg::CTL_CR, jsu_pkg::ERR_NONE);
						n    = 3'd1;
					end
					jsu_pkg::CH_T: begin
						r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, jsu_pkg::CTL_TAB, jsu_pkg::ERR_NONE);
						n    = 3'd1;
					end
					default: begin
						if (byte_s1 == jsu_pkg::CH_U && dec_q) begin
							fu_d  = '0;
							dig_d = 2'd0;
							ph_d  = PH_HI;
						end else begin
							r[0]     = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, jsu_pkg::CH_BSLASH,
								jsu_pkg::ERR_NONE);
							n        = 3'd1;
							do_plain = 1'b1;
						end
					end
				endcase
			end
			PH_HI: begin
				if (!h.ok) begin
					r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_BAD_HEX);
					n    = 3'd1;
					ph_d = PH_IDLE;
				end else begin
					fu_d = {fu_q[11:0], h.val};
					if (dig_q != 2'd3) begin
						dig_d = 2'(dig_q + 2'd1);
					end else if (fu_d[15:10] == jsu_pkg::SURR_HIGH) begin
						ph_d = PH_BSL;
					end else if (fu_d[15:11] == jsu_pkg::SURR_ANY) begin
						r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_BAD_CP);
						n    = 3'd1;
						ph_d = PH_IDLE;
					end else begin
						cp     = {5'd0, fu_d};
						do_enc = 1'b1;
					end
				end
			end
			PH_BSL: begin
				if (byte_s1 == jsu_pkg::CH_BSLASH) begin
					ph_d = PH_UCH;
				end else begin
					r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_BAD_SURR);
					n    = 3'd1;
					ph_d = PH_IDLE;
				end
			end
			PH_UCH: begin
				if (byte_s1 == jsu_pkg::CH_U) begin
					su_d  = '0;
					dig_d = 2'd0;
					ph_d  = PH_LO;
				end else begin
					r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_BAD_SURR);
					n    = 3'd1;
					ph_d = PH_IDLE;
				end
			end
			PH_LO: begin
				if (!h.ok) begin
					r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_BAD_SURR);
					n    = 3'd1;
					ph_d = PH_IDLE;
				end else begin
					su_d = {su_q[11:0], h.val};
					if (dig_q != 2'd3) begin
						dig_d = 2'(dig_q + 2'd1);
					end else if (su_d[15:10] != jsu_pkg::SURR_LOW) begin
						r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_BAD_SURR);
						n    = 3'd1;
						ph_d = PH_IDLE;
					end else begin
						cp     = jsu_pkg::CP_FOUR_BYTE + {1'b0, fu_q[9:0], su_d[9:0]};
						do_enc = 1'b1;
					end
				end
			end
			PH_IDLE: begin
				ph_d = PH_IDLE;
			end
			default: begin
				ph_d = PH_IDLE;
			end
		endcase

		if (do_plain) begin
			if (byte_s1 == jsu_pkg::CH_NUL) begin
				r[n[1:0]] = jsu_pkg::mk_res(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_NO_CLOSE);
				n         = 3'(n + 3'd1);
				ph_d      = PH_IDLE;
			end else if (byte_s1 == jsu_pkg::CH_QUOTE) begin
				r[n[1:0]] = jsu_pkg::mk_res(jsu_pkg::KIND_END, 8'h00, jsu_pkg::ERR_NONE);
				n         = 3'(n + 3'd1);
				ph_d      = PH_IDLE;
			end else if (byte_s1 == jsu_pkg::CH_BSLASH) begin
				ph_d = PH_ESC;
			end else begin
				r[n[1:0]] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, byte_s1, jsu_pkg::ERR_NONE);
				n         = 3'(n + 3'd1);
				ph_d      = PH_TEXT;
			end
		end

		if (do_enc) begin
			ph_d = PH_TEXT;
			if (cp < jsu_pkg::CP_TWO_BYTE) begin
				r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, cp[7:0], jsu_pkg::ERR_NONE);
				n    = 3'd1;
			end else if (cp < jsu_pkg::CP_THREE_BYTE) begin
				r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, {3'b110, cp[10:6]}, jsu_pkg::ERR_NONE);
				r[1] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, {2'b10, cp[5:0]}, jsu_pkg::ERR_NONE);
				n    = 3'd2;
			end else if (cp < jsu_pkg::CP_FOUR_BYTE) begin
				r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, {4'b1110, cp[15:12]}, jsu_pkg::ERR_NONE);
				r[1] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, {2'b10, cp[11:6]}, jsu_pkg::ERR_NONE);
				r[2] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, {2'b10, cp[5:0]}, jsu_pkg::ERR_NONE);
				n    = 3'd3;
			end else begin
				r[0] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, {5'b11110, cp[20:18]}, jsu_pkg::ERR_NONE);
				r[1] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, {2'b10, cp[17:12]}, jsu_pkg::ERR_NONE);
				r[2] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, {2'b10, cp[11:6]}, jsu_pkg::ERR_NONE);
				r[3] = jsu_pkg::mk_res(jsu_pkg::KIND_DATA, {2'b10, cp[5:0]}, jsu_pkg::ERR_NONE);
				n    = 3'd4;
			end
		end
	end

	assign out_hs   = decoded.valid && decoded.ready;
	assign buf_free = (cnt_s2 == 3'd0) || (cnt_s2 == 3'd1 && decoded.ready);
	assign adv      = vld_s1 && (n == 3'd0 || buf_free);

	assign raw.ready = !vld_s1 || adv;
	assign cfg.ready = 1'b1;

	assign decoded.valid       = (cnt_s2 != 3'd0);
	assign decoded.out_byte    = res_s2[0].out_byte;
	assign decoded.result_kind = res_s2[0].kind;
	assign decoded.error_code  = res_s2[0].code;
	assign decoded.last_in_run = (cnt_s2 == 3'd1);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (raw.ready) begin
			vld_s1 <= raw.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw.ready && raw.valid) begin
			byte_s1  <= raw.in_byte;
			start_s1 <= raw.starts_string;
		end
	end

	// decoder state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_IDLE;
			dig_q <= 2'd0;
			fu_q  <= '0;
			su_q  <= '0;
			dec_q <= 1'b1;
		end else begin
			if (adv) begin
				ph_q  <= ph_d;
				dig_q <= dig_d;
				fu_q  <= fu_d;
				su_q  <= su_d;
			end
			if (cfg.valid && cfg.ready) begin
				dec_q <= cfg.decode_unicode;
			end
		end
	end

	// result buffer: load a whole run, drain one word per handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= 3'd0;
		end else if (adv && n != 3'd0) begin
			cnt_s2 <= n;
		end else if (out_hs) begin
			cnt_s2 <= 3'(cnt_s2 - 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && n != 3'd0) begin
			for (int i = 0; i < 4; i++) begin
				res_s2[i] <= r[i];
			end
		end else if (out_hs) begin
			for (int i = 0; i < 3; i++) begin
				res_s2[i] <= res_s2[i+1];
			end
		end
	end

endmodule

FILE: tb/json_string_unescape_utf8_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top_tb
// Self-checking bench for the JSON string unescaper. A queue of string-body
// bytes feeds a bursty driver. A local decoder predicts the data, end and
// error words of every accepted byte, and the monitor compares them word by
// word against the output under a randomly stalling receiver. Runs a short
// directed set, then random strings with decoding switched off and on.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top_tb;

	typedef struct {
		logic [7:0] ch;
		logic       first;
	} raw_word_t;

	typedef struct {
		logic [7:0]     data;
		jsu_pkg::kind_t kind;
		jsu_pkg::err_t  code;
		logic           last;
	} decoded_word_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_TEXT, ST_ESC, ST_HI, ST_BSL, ST_UCH, ST_LO
	} scan_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_BURSTY, RX_LIGHT} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	jsu_in_if  raw_ch();
	jsu_out_if decoded_ch();
	jsu_cfg_if cfg_ch();

	json_string_unescape_utf8_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.raw     (raw_ch),
		.decoded (decoded_ch),
		.cfg     (cfg_ch)
	);

	raw_word_t     raw_words[$];
	decoded_word_t decoded_due[$];
	decoded_word_t run_words[$];
	raw_word_t     taken;
	decoded_word_t want;

	scan_t       scan;
	int          digits;
	logic [15:0] hi_unit;
	logic [15:0] lo_unit;
	logic        decode_on;

	int       fails;
	int       phase_items;
	logic     pending_start;
	int       burst_left;
	int       gap_left;
	int       stall_left;
	int       mode_left;
	rx_mode_t rx_mode;

	always #5 clk = ~clk;

	task automatic note_failure(string msg);
		$display("%0t ns: %s", $realtime, msg);
		fails++;
	endtask

	// decoder prediction
	function automatic int nibble_of(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	task automatic put_word(jsu_pkg::kind_t k, logic [7:0] b, jsu_pkg::err_t e);
		decoded_word_t w;
		w.data = b;
		w.kind = k;
		w.code = e;
		w.last = 1'b0;
		run_words.push_back(w);
	endtask

	task automatic put_error(jsu_pkg::err_t e);
		put_word(jsu_pkg::KIND_ERR, 8'h00, e);
		scan = ST_IDLE;
	endtask

	task automatic take_plain(logic [7:0] c);
		if (c == jsu_pkg::CH_NUL) begin
			put_error(jsu_pkg::ERR_NO_CLOSE);
		end else if (c == jsu_pkg::CH_QUOTE) begin
			put_word(jsu_pkg::KIND_END, 8'h00, jsu_pkg::ERR_NONE);
			scan = ST_IDLE;
		end else if (c == jsu_pkg::CH_BSLASH) begin
			scan = ST_ESC;
		end else begin
			put_word(jsu_pkg::KIND_DATA, c, jsu_pkg::ERR_NONE);
			scan = ST_TEXT;
		end
	endtask

	task automatic emit_utf8(logic [20:0] cp);
		if (cp < jsu_pkg::CP_TWO_BYTE) begin
			put_word(jsu_pkg::KIND_DATA, cp[7:0], jsu_pkg::ERR_NONE);
		end else if (cp < jsu_pkg::CP_THREE_BYTE) begin
			put_word(jsu_pkg::KIND_DATA, {3'b110, cp[10:6]}, jsu_pkg::ERR_NONE);
			put_word(jsu_pkg::KIND_DATA, {2'b10, cp[5:0]}, jsu_pkg::ERR_NONE);
		end else if (cp < jsu_pkg::CP_FOUR_BYTE) begin
			put_word(jsu_pkg::KIND_DATA, {4'b1110, cp[15:12]}, jsu_pkg::ERR_NONE);
			put_word(jsu_pkg::KIND_DATA, {2'b10, cp[11:6]}, jsu_pkg::ERR_NONE);
			put_word(jsu_pkg::KIND_DATA, {2'b10, cp[5:0]}, jsu_pkg::ERR_NONE);
		end else begin
			put_word(jsu_pkg::KIND_DATA, {5'b11110, cp[20:18]}, jsu_pkg::ERR_NONE);
			put_word(jsu_pkg::KIND_DATA, {2'b10, cp[17:12]}, jsu_pkg::ERR_NONE);
			put_word(jsu_pkg::KIND_DATA, {2'b10, cp[11:6]}, jsu_pkg::ERR_NONE);
			put_word(jsu_pkg::KIND_DATA, {2'b10, cp[5:0]}, jsu_pkg::ERR_NONE);
		end
		scan = ST_TEXT;
	endtask

	task automatic unescape_byte(logic [7:0] c, logic first);
		int h;
		logic [20:0] cp;
		run_words.delete();
		if (first) begin
			scan = ST_TEXT;
			hi_unit = '0;
			lo_unit = '0;
		end
		case (scan)
			ST_TEXT: begin
				take_plain(c);
			end
			ST_ESC: begin
				scan = ST_TEXT;
				case (c)
					jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH, jsu_pkg::CH_QUOTE:
						put_word(jsu_pkg::KIND_DATA, c, jsu_pkg::ERR_NONE);
					jsu_pkg::CH_B: put_word(jsu_pkg::KIND_DATA, jsu_pkg::CTL_BS, jsu_pkg::ERR_NONE);
					jsu_pkg::CH_F: put_word(jsu_pkg::KIND_DATA, jsu_pkg::CTL_FF, jsu_pkg::ERR_NONE);
					jsu_pkg::CH_N: put_word(jsu_pkg::KIND_DATA, jsu_pkg::CTL_LF, jsu_pkg::ERR_NONE);
					jsu_pkg::CH_R: put_word(jsu_pkg::KIND_DATA, jsu_pkg::CTL_CR, jsu_pkg::ERR_NONE);
					jsu_pkg::CH_T: put_word(jsu_pkg::KIND_DATA, jsu_pkg::CTL_TAB, jsu_pkg::ERR_NONE);
					default: begin
						if (c == jsu_pkg::CH_U && decode_on) begin
							hi_unit = '0;
							digits = 0;
							scan = ST_HI;
						end else begin
							put_word(jsu_pkg::KIND_DATA, jsu_pkg::CH_BSLASH, jsu_pkg::ERR_NONE);
							take_plain(c);
						end
					end
				endcase
			end
			ST_HI: begin
				h = nibble_of(c);
				if (h < 0) begin
					put_error(jsu_pkg::ERR_BAD_HEX);
				end else begin
					hi_unit = {hi_unit[11:0], 4'(h)};
					digits++;
					if (digits < 4) begin
					end else if (hi_unit[15:10] == jsu_pkg::SURR_HIGH) begin
						scan = ST_BSL;
					end else if (hi_unit[15:11] == jsu_pkg::SURR_ANY) begin
						put_error(jsu_pkg::ERR_BAD_CP);
					end else begin
						emit_utf8({5'd0, hi_unit});
					end
				end
			end
			ST_BSL: begin
				if (c == jsu_pkg::CH_BSLASH) scan = ST_UCH;
				else put_error(jsu_pkg::ERR_BAD_SURR);
			end
			ST_UCH: begin
				if (c == jsu_pkg::CH_U) begin
					lo_unit = '0;
					digits = 0;
					scan = ST_LO;
				end else begin
					put_error(jsu_pkg::ERR_BAD_SURR);
				end
			end
			ST_LO: begin
				h = nibble_of(c);
				if (h < 0) begin
					put_error(jsu_pkg::ERR_BAD_SURR);
				end else begin
					lo_unit = {lo_unit[11:0], 4'(h)};
					digits++;
					if (digits < 4) begin
					end else if (lo_unit[15:10] != jsu_pkg::SURR_LOW) begin
						put_error(jsu_pkg::ERR_BAD_SURR);
					end else begin
						cp = jsu_pkg::CP_FOUR_BYTE + {1'b0, hi_unit[9:0], lo_unit[9:0]};
						if (cp < 21'h110000) emit_utf8(cp);
						else put_error(jsu_pkg::ERR_BAD_CP);
					end
				end
			end
			default: begin
				scan = ST_IDLE;
			end
		endcase
		if (run_words.size() > 0) run_words[$].last = 1'b1;
		foreach (run_words[i]) decoded_due.push_back(run_words[i]);
	endtask

	// sender: bursts with random gaps, predict on every accepted word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_ch.valid <= 1'b0;
			raw_ch.in_byte <= '0;
			raw_ch.starts_string <= 1'b0;
			burst_left = $urandom_range(1, 30);
			gap_left = 0;
		end else begin
			if (raw_ch.valid && raw_ch.ready) begin
				taken = raw_words.pop_front();
				unescape_byte(taken.ch, taken.first);
				if (burst_left > 0) burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 :
						($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) :
						$urandom_range(1, 5);
				end
			end
			if (!raw_ch.valid || raw_ch.ready) begin
				if (gap_left > 0) begin
					raw_ch.valid <= 1'b0;
					gap_left--;
				end else if (raw_words.size() > 0) begin
					raw_ch.valid <= 1'b1;
					raw_ch.in_byte <= raw_words[0].ch;
					raw_ch.starts_string <= raw_words[0].first;
				end else begin
					raw_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern switches between open, coin-flip, bursty and light-stall modes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decoded_ch.ready <= 1'b0;
			stall_left = 0;
			mode_left = 0;
			rx_mode = RX_OPEN;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			if (stall_left > 0) begin
				decoded_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				case (rx_mode)
					RX_OPEN: decoded_ch.ready <= 1'b1;
					RX_COIN: decoded_ch.ready <= 1'($urandom_range(0, 1));
					RX_BURSTY: begin
						decoded_ch.ready <= 1'b1;
						if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(3, 15);
					end
					default: decoded_ch.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && decoded_ch.valid && decoded_ch.ready) begin
			if (decoded_due.size() == 0) begin
				note_failure($sformatf("unexpected word: kind %0d byte %02h code %0d",
					decoded_ch.result_kind, decoded_ch.out_byte, decoded_ch.error_code));
			end else begin
				want = decoded_due.pop_front();
				if (decoded_ch.out_byte !== want.data)
					note_failure($sformatf("out_byte %02h, want %02h",
						decoded_ch.out_byte, want.data));
				if (decoded_ch.result_kind !== want.kind)
					note_failure($sformatf("result_kind %0d, want %0d",
						decoded_ch.result_kind, want.kind));
				if (decoded_ch.error_code !== want.code)
					note_failure($sformatf("error_code %0d, want %0d",
						decoded_ch.error_code, want.code));
				if (decoded_ch.last_in_run !== want.last)
					note_failure($sformatf("last_in_run %0b, want %0b",
						decoded_ch.last_in_run, want.last));
			end
		end
	end

	// stimulus helpers
	task automatic push_word(logic [7:0] ch);
		raw_word_t w;
		w.ch = ch;
		w.first = pending_start;
		pending_start = 1'b0;
		raw_words.push_back(w);
		phase_items++;
	endtask

	task automatic push_stray(logic [7:0] ch);
		raw_word_t w;
		w.ch = ch;
		w.first = 1'b0;
		raw_words.push_back(w);
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] n);
		logic upper;
		upper = 1'($urandom_range(0, 1));
		if (n < 4'd10) return "0" + n;
		if (upper) return "A" + n - 8'd10;
		return "a" + n - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (nibble_of(b) >= 0);
		return b;
	endfunction

	task automatic push_hex_digits(logic [15:0] v, int count);
		for (int i = 3; i > 3 - count; i--) push_word(hex_char(v[4*i +: 4]));
	endtask

	task automatic push_unicode(logic [15:0] v);
		push_word(jsu_pkg::CH_BSLASH);
		push_word(jsu_pkg::CH_U);
		push_hex_digits(v, 4);
	endtask

	function automatic logic [15:0] high_unit();
		return 16'($urandom_range(16'hd800, 16'hdbff));
	endfunction

	function automatic logic [15:0] low_unit();
		return 16'($urandom_range(16'hdc00, 16'hdfff));
	endfunction

	task automatic push_broken_unicode();
		logic [7:0] b;
		logic [15:0] v;
		case ($urandom_range(0, 5))
			0: begin
				push_word(jsu_pkg::CH_BSLASH);
				push_word(jsu_pkg::CH_U);
				push_hex_digits(16'($urandom), $urandom_range(0, 3));
				push_word(non_hex());
			end
			1: push_unicode(low_unit());
			2: begin
				push_unicode(high_unit());
				do b = 8'($urandom_range(0, 255)); while (b == jsu_pkg::CH_BSLASH);
				push_word(b);
			end
			3: begin
				push_unicode(high_unit());
				push_word(jsu_pkg::CH_BSLASH);
				do b = 8'($urandom_range(0, 255)); while (b == jsu_pkg::CH_U);
				push_word(b);
			end
			4: begin
				push_unicode(high_unit());
				push_word(jsu_pkg::CH_BSLASH);
				push_word(jsu_pkg::CH_U);
				push_hex_digits(low_unit(), $urandom_range(0, 3));
				push_word(non_hex());
			end
			default: begin
				push_unicode(high_unit());
				do v = 16'($urandom); while (v[15:10] == jsu_pkg::SURR_LOW);
				push_unicode(v);
			end
		endcase
	endtask

	task automatic push_random_string();
		logic [7:0] b;
		logic [15:0] v;
		int segs;
		logic [7:0] escapes[8];
		escapes = '{jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH, jsu_pkg::CH_QUOTE, jsu_pkg::CH_B,
			jsu_pkg::CH_F, jsu_pkg::CH_N, jsu_pkg::CH_R, jsu_pkg::CH_T};
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3)) push_stray(8'($urandom_range(0, 255)));
		pending_start = 1'b1;
		segs = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 8);
		repeat (segs) begin
			case ($urandom_range(0, 11))
				0, 1, 2, 3: begin
					do b = 8'($urandom_range(1, 255));
					while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
					push_word(b);
				end
				4: begin
					push_word(jsu_pkg::CH_BSLASH);
					push_word(escapes[$urandom_range(0, 7)]);
				end
				5, 6: begin
					case ($urandom_range(0, 2))
						0: v = 16'($urandom_range(0, 16'h7f));
						1: v = 16'($urandom_range(16'h80, 16'h7ff));
						default: do v = 16'($urandom_range(16'h800, 16'hffff));
							while (v[15:11] == jsu_pkg::SURR_ANY);
					endcase
					push_unicode(v);
				end
				7: begin
					push_unicode(high_unit());
					push_unicode(low_unit());
				end
				8: begin
					push_word(jsu_pkg::CH_BSLASH);
					push_word(8'($urandom_range(0, 255)));
				end
				9: begin
					push_broken_unicode();
					return;
				end
				10: begin
					push_word(jsu_pkg::CH_NUL);
					return;
				end
				default: push_word(8'($urandom_range(0, 255)));
			endcase
		end
		if (pending_start || $urandom_range(0, 7) != 0) push_word(jsu_pkg::CH_QUOTE);
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (raw_words.size() != 0 || raw_ch.valid || decoded_due.size() != 0);
	endtask

	task automatic write_decode(logic on);
		wait_drained();
		repeat (6) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.decode_unicode <= on;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		cfg_ch.valid <= 1'b0;
		decode_on = on;
	endtask

	initial begin
		logic plan[4];
		plan = '{1'b0, 1'b1, 1'b0, 1'b1};
		fails = 0;
		phase_items = 0;
		pending_start = 1'b0;
		decode_on = 1'b1;
		scan = ST_IDLE;
		digits = 0;
		hi_unit = '0;
		lo_unit = '0;
		arst_n = 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.decode_unicode <= 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		write_decode(1'b1);
		// byte extremes, an escape, end
		pending_start = 1'b1;
		push_word(8'hff);
		push_word(8'h01);
		push_word(jsu_pkg::CH_BSLASH);
		push_word(jsu_pkg::CH_N);
		push_word(jsu_pkg::CH_QUOTE);
		// ignored while idle
		push_stray("z");
		// unknown escape, then restart mid-string on a zero byte
		pending_start = 1'b1;
		push_word(jsu_pkg::CH_BSLASH);
		push_word("q");
		pending_start = 1'b1;
		push_word(jsu_pkg::CH_NUL);
		// bad hex, lone low surrogate, high surrogate without its pair
		pending_start = 1'b1;
		push_word(jsu_pkg::CH_BSLASH);
		push_word(jsu_pkg::CH_U);
		push_word("g");
		pending_start = 1'b1;
		push_unicode(16'hdc00);
		pending_start = 1'b1;
		push_unicode(16'hd800);
		push_word("x");
		// empty string
		pending_start = 1'b1;
		push_word(jsu_pkg::CH_QUOTE);

		foreach (plan[p]) begin
			write_decode(plan[p]);
			phase_items = 0;
			while (phase_items < 92) begin
				push_random_string();
				if ($urandom_range(0, 11) == 0) wait_drained();
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (fails == 0 && decoded_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
